@@ design/disk_request_scheduler_assert.svh @@
// Assertion macros used by the disk request scheduler datapath.
`ifndef DISK_REQUEST_SCHEDULER_ASSERT_SVH
`define DISK_REQUEST_SCHEDULER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define DRS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define DRS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ design/dsched_pkg.sv @@
// Shared types and constants of the disk request scheduler.
package dsched_pkg;

   // Fixed field widths of the stream and register ports
   localparam int FLD_W        = 16;
   localparam int SUM_W        = 22;
   localparam int RSP_DATA_W   = 72;
   localparam int CSR_IDX_BITS = 2;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_POLICY     = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_START_HEAD = 2'd1;

   // Policy codes
   localparam logic [1:0] POL_SSTF  = 2'd0;
   localparam logic [1:0] POL_LOOK  = 2'd1;
   localparam logic [1:0] POL_CLOOK = 2'd2;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_PICK,
      ST_EMIT
   } dsched_state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic accept;     // store the incoming request
      logic start;      // open the schedule of the closed batch
      logic scan_clr;   // restart the candidate scan
      logic scan_step;  // advance the candidate scan
      logic pick;       // latch the chosen candidate
      logic emit;       // load the result register and retire the move
   } dsched_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic scan_done;
      logic final_move;
      logic out_free;
   } dsched_sts_type;

endpackage

@@ design/dsched_ram.sv @@
// Generic simple dual-port RAM with registered read.
module dsched_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ design/dsched_ctrl.sv @@
// Controller state machine: batch loading, scan, pick and result issue.
module dsched_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tlast,
   output logic                    req_tready,
   input  dsched_pkg::dsched_sts_type sts,
   output dsched_pkg::dsched_cmd_type cmd
);
   import dsched_pkg::*;

   dsched_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (req_tlast) begin
                  cmd.start    = 1'b1;
                  cmd.scan_clr = 1'b1;
                  state_in     = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            cmd.pick = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.final_move) begin
                  state_in = ST_LOAD;
               end else begin
                  cmd.scan_clr = 1'b1;
                  state_in     = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end
endmodule

@@ design/dsched_dp.sv @@
// Datapath: request store, pending set, candidate scan, head and seek tracking.
module dsched_dp #(
   parameter int MAX_REQUESTS = 32,
   parameter int TRACK_BITS   = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  dsched_pkg::dsched_cmd_type             cmd,
   output dsched_pkg::dsched_sts_type             sts,
   input  logic [dsched_pkg::FLD_W-1:0]           req_track,
   input  logic                                   csr_valid,
   input  logic [dsched_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [dsched_pkg::FLD_W-1:0]           csr_data,
   input  logic                                   rsp_tready,
   output logic                                   rsp_tvalid,
   output logic [dsched_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                   rsp_tlast,
   output logic                                   rsp_tuser
);
   import dsched_pkg::*;

   localparam int SW = (TRACK_BITS < FLD_W) ? TRACK_BITS : FLD_W;
   localparam int IW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int CW = $clog2(MAX_REQUESTS + 1);

   typedef struct packed {
      logic          vld;
      logic [SW-1:0] trk;
      logic [IW-1:0] idx;
   } cand_type;

   // Configuration
   logic [1:0]          policy_ff, policy_in;
   logic [SW-1:0]       start_ff, start_in;

   // Batch state
   logic [MAX_REQUESTS-1:0] pending_ff, pending_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       move_ff, move_in;
   logic [SW-1:0]       head_ff, head_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic                sweep_ff, sweep_in;
   logic                dropped_ff, dropped_in;

   // Scan pipeline
   logic [CW-1:0]       iss_ff, iss_in;
   logic                cmp_vld_ff, cmp_vld_in;
   logic [IW-1:0]       cmp_idx_ff, cmp_idx_in;
   cand_type            any_ff, any_in, up_ff, up_in, dn_ff, dn_in, lo_ff, lo_in;
   logic [SW-1:0]       any_d_ff, any_d_in;

   // Chosen move
   cand_type            chosen;
   logic [SW-1:0]       sel_trk_ff, sel_trk_in;
   logic [IW-1:0]       sel_idx_ff, sel_idx_in;
   logic [SW-1:0]       sel_d_ff, sel_d_in;

   // Result register
   logic                out_vld_ff, out_vld_in;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic                out_last_ff, out_last_in;
   logic                out_user_ff, out_user_in;

   // Store and scan helpers
   logic                wr_en, rd_en, eval, t_ge, t_le, final_move;
   logic [SW-1:0]       rd_data, t_dist;
   logic [SUM_W-1:0]    sum_new;

   assign wr_en = cmd.accept && (count_ff < CW'(MAX_REQUESTS));
   assign rd_en = cmd.scan_step && (iss_ff < count_ff);

   dsched_ram #(
      .WIDTH (SW),
      .DEPTH (MAX_REQUESTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IW-1:0]),
      .wr_data (req_track[SW-1:0]),
      .rd_en   (rd_en),
      .rd_addr (iss_ff[IW-1:0]),
      .rd_data (rd_data)
   );

   // Compare the fetched track against the head
   assign eval   = cmp_vld_ff && pending_ff[cmp_idx_ff];
   assign t_ge   = rd_data >= head_ff;
   assign t_le   = rd_data <= head_ff;
   assign t_dist = t_ge ? (rd_data - head_ff) : (head_ff - rd_data);

   assign final_move = (move_ff + 1'b1) == count_ff;
   assign sum_new    = sum_ff + SUM_W'(sel_d_ff);

   assign sts.scan_done  = (iss_ff == count_ff) && !cmp_vld_ff;
   assign sts.final_move = final_move;
   assign sts.out_free   = !out_vld_ff || rsp_tready;

   // Select the move by policy; strict compares keep the lowest slot on ties
   always_comb begin
      chosen = any_ff;
      case (policy_ff)
         POL_LOOK: begin
            if (sweep_ff) begin
               chosen = up_ff.vld ? up_ff : dn_ff;
            end else begin
               chosen = dn_ff.vld ? dn_ff : up_ff;
            end
         end
         POL_CLOOK: begin
            chosen = up_ff.vld ? up_ff : lo_ff;
         end
         default: begin
            chosen = any_ff;
         end
      endcase
   end

   // Next-state logic
   always_comb begin
      policy_in   = policy_ff;
      start_in    = start_ff;
      pending_in  = pending_ff;
      count_in    = count_ff;
      move_in     = move_ff;
      head_in     = head_ff;
      sum_in      = sum_ff;
      sweep_in    = sweep_ff;
      dropped_in  = dropped_ff;
      iss_in      = iss_ff;
      cmp_vld_in  = 1'b0;
      cmp_idx_in  = cmp_idx_ff;
      any_in      = any_ff;
      any_d_in    = any_d_ff;
      up_in       = up_ff;
      dn_in       = dn_ff;
      lo_in       = lo_ff;
      sel_trk_in  = sel_trk_ff;
      sel_idx_in  = sel_idx_ff;
      sel_d_in    = sel_d_ff;
      out_vld_in  = out_vld_ff && !rsp_tready;
      out_data_in = out_data_ff;
      out_last_in = out_last_ff;
      out_user_in = out_user_ff;

      // Take register writes
      if (csr_valid) begin
         case (csr_index)
            CSR_POLICY:     policy_in = csr_data[1:0];
            CSR_START_HEAD: start_in  = csr_data[SW-1:0];
            default: ;
         endcase
      end

      // Store a request, or flag it dropped when the batch is full
      if (cmd.accept) begin
         if (wr_en) begin
            pending_in[count_ff[IW-1:0]] = 1'b1;
            count_in = count_ff + 1'b1;
         end else begin
            dropped_in = 1'b1;
         end
      end

      // Open the schedule
      if (cmd.start) begin
         head_in  = start_ff;
         sum_in   = '0;
         sweep_in = 1'b1;
         move_in  = '0;
      end

      // Scan: issue reads, then fold each pending track into the candidates
      if (cmd.scan_clr) begin
         iss_in     = '0;
         any_in.vld = 1'b0;
         up_in.vld  = 1'b0;
         dn_in.vld  = 1'b0;
         lo_in.vld  = 1'b0;
      end else begin
         if (rd_en) begin
            iss_in     = iss_ff + 1'b1;
            cmp_vld_in = 1'b1;
            cmp_idx_in = iss_ff[IW-1:0];
         end
         if (eval) begin
            if (!any_ff.vld || t_dist < any_d_ff) begin
               any_in   = '{vld: 1'b1, trk: rd_data, idx: cmp_idx_ff};
               any_d_in = t_dist;
            end
            if (t_ge && (!up_ff.vld || rd_data < up_ff.trk)) begin
               up_in = '{vld: 1'b1, trk: rd_data, idx: cmp_idx_ff};
            end
            if (t_le && (!dn_ff.vld || rd_data > dn_ff.trk)) begin
               dn_in = '{vld: 1'b1, trk: rd_data, idx: cmp_idx_ff};
            end
            if (!lo_ff.vld || rd_data < lo_ff.trk) begin
               lo_in = '{vld: 1'b1, trk: rd_data, idx: cmp_idx_ff};
            end
         end
      end

      // Latch the chosen move; under LOOK, reverse the sweep when its side is empty
      if (cmd.pick) begin
         sel_trk_in = chosen.trk;
         sel_idx_in = chosen.idx;
         sel_d_in   = (chosen.trk >= head_ff) ? (chosen.trk - head_ff)
                                               : (head_ff - chosen.trk);
         if (policy_ff == POL_LOOK) begin
            if (sweep_ff && !up_ff.vld) begin
               sweep_in = 1'b0;
            end else if (!sweep_ff && !dn_ff.vld) begin
               sweep_in = 1'b1;
            end
         end
      end

      // Issue the result transaction and retire the move; the final move clears the batch
      if (cmd.emit) begin
         out_vld_in  = 1'b1;
         out_data_in = {{(RSP_DATA_W - 3*FLD_W - SUM_W){1'b0}}, sum_new,
                        FLD_W'(sel_d_ff), FLD_W'(sel_trk_ff), FLD_W'(head_ff)};
         out_last_in = final_move;
         out_user_in = dropped_ff;
         head_in     = sel_trk_ff;
         sum_in      = sum_new;
         move_in     = move_ff + 1'b1;
         pending_in[sel_idx_ff] = 1'b0;
         if (final_move) begin
            pending_in = '0;
            count_in   = '0;
            sum_in     = '0;
            sweep_in   = 1'b1;
            dropped_in = 1'b0;
            move_in    = '0;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff  <= POL_SSTF;
         start_ff   <= '0;
         pending_ff <= '0;
         count_ff   <= '0;
         move_ff    <= '0;
         head_ff    <= '0;
         sum_ff     <= '0;
         sweep_ff   <= 1'b1;
         dropped_ff <= 1'b0;
         iss_ff     <= '0;
         cmp_vld_ff <= 1'b0;
         any_ff     <= '0;
         up_ff      <= '0;
         dn_ff      <= '0;
         lo_ff      <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         policy_ff  <= policy_in;
         start_ff   <= start_in;
         pending_ff <= pending_in;
         count_ff   <= count_in;
         move_ff    <= move_in;
         head_ff    <= head_in;
         sum_ff     <= sum_in;
         sweep_ff   <= sweep_in;
         dropped_ff <= dropped_in;
         iss_ff     <= iss_in;
         cmp_vld_ff <= cmp_vld_in;
         any_ff     <= any_in;
         up_ff      <= up_in;
         dn_ff      <= dn_in;
         lo_ff      <= lo_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmp_idx_ff  <= cmp_idx_in;
      any_d_ff    <= any_d_in;
      sel_trk_ff  <= sel_trk_in;
      sel_idx_ff  <= sel_idx_in;
      sel_d_ff    <= sel_d_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
      out_user_ff <= out_user_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_user_ff;

`include "disk_request_scheduler_assert.svh"

   `DRS_ASSERT_ALWAYS(a_reset_clears, reset |=> !out_vld_ff && count_ff == '0, "reset left state")
   `DRS_ASSERT(a_emit_free, cmd.emit |-> (!out_vld_ff || rsp_tready), "result overwritten")
   `DRS_ASSERT(a_scan_bound, cmp_vld_ff |-> (CW'(cmp_idx_ff) < count_ff), "scan beyond batch")
   `DRS_ASSERT(a_pick_cand, cmd.pick |-> any_ff.vld, "pick with no pending request")
   `DRS_ASSERT(a_batch_close, (cmd.emit && final_move) |=> (pending_ff == '0), "batch not cleared")
endmodule

@@ design/disk_request_scheduler.sv @@
// Loading: one request transaction per cycle; the batch closes on tlast.
// Each result is found in steps: store reads, a compare of each fetched track,
// a scan-done check, pick and issue; result stalls delay the issue.
// Synchronous active-high reset clears the batch, selects shortest seek first
// and a start head of zero; store contents are not cleared.
module disk_request_scheduler #(
   parameter int MAX_REQUESTS = 32,
   parameter int TRACK_BITS   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [dsched_pkg::FLD_W-1:0]        req_tdata,   // [15:0] track
   input  logic                                req_tlast,   // last of batch
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [15:0] from_pos, [31:16] to_pos, [47:32] seek, [69:48] total_seek
   output logic [dsched_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                                rsp_tlast,   // end_of_batch
   output logic                                rsp_tuser,   // [0] overflow
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dsched_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [dsched_pkg::FLD_W-1:0]        csr_data
);
   import dsched_pkg::*;

   dsched_cmd_type cmd;
   dsched_sts_type sts;

   // Register writes are always taken
   assign csr_ready = 1'b1;

   dsched_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   dsched_dp #(
      .MAX_REQUESTS (MAX_REQUESTS),
      .TRACK_BITS   (TRACK_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_track  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );
endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the disk request scheduler: batches in, service moves out.
`timescale 1ns / 100ps

module tb;
   import dsched_pkg::*;

   localparam int MAX_SLOTS      = 32;
   localparam int SETTLE_CYCLES  = 40;    // one full scan of a loaded store plus margin
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 50;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE = 2'd3;  // unmapped register index

   typedef struct packed {
      logic [FLD_W-1:0] from_pos;
      logic [FLD_W-1:0] to_pos;
      logic [FLD_W-1:0] seek;
      logic [SUM_W-1:0] total_seek;
      logic             end_of_batch;
      logic             overflow;
   } move_type;

   typedef enum {SEL_NEAREST, SEL_ABOVE, SEL_BELOW, SEL_LOWEST} select_type;
   typedef enum {ROW_REQ, ROW_CFG} row_kind_type;

   typedef struct {
      row_kind_type     kind;
      logic [CSR_IDX_BITS-1:0] idx;
      logic [FLD_W-1:0] val;
      logic             lst;
      logic             pinned;
      move_type         mv;
   } dir_row_type;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [FLD_W-1:0]        req_tdata;
   logic                    req_tlast;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tlast;
   logic                    rsp_tuser;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [FLD_W-1:0]        csr_data;

   // Scheduler shadow state
   logic [FLD_W-1:0] trk_slot [MAX_SLOTS];
   logic             slot_live [MAX_SLOTS];
   int               slot_count = 0;
   logic [FLD_W-1:0] head_track = '0;
   logic [22:0]      seek_acc   = '0;
   logic             going_up   = 1'b1;
   logic             drop_seen  = 1'b0;
   logic [1:0]       cfg_policy = POL_SSTF;
   logic [FLD_W-1:0] cfg_start  = '0;

   move_type    expected_moves [$];
   dir_row_type dir_rows [$];

   logic     pin_next = 1'b0;
   move_type pin_move;
   int       mismatches = 0;
   int       idle_cycles = 0;
   int       snd_idle = 8;
   int       rcv_idle = 49;
   logic [FLD_W-1:0] prev_track = '0;

   disk_request_scheduler u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   function automatic logic [FLD_W-1:0] abs_diff(input logic [FLD_W-1:0] a,
                                                 input logic [FLD_W-1:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   // Find the best pending slot for a selection rule; lowest slot wins ties
   function automatic int best_slot(input select_type m);
      int               best;
      logic [FLD_W-1:0] key;
      logic [FLD_W-1:0] best_key;
      logic [FLD_W-1:0] t;
      best     = -1;
      best_key = '0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
         if (!slot_live[i]) continue;
         t = trk_slot[i];
         if (m == SEL_ABOVE && t < head_track) continue;
         if (m == SEL_BELOW && t > head_track) continue;
         key = (m == SEL_LOWEST) ? t : abs_diff(t, head_track);
         if (best < 0 || key < best_key) begin
            best     = i;
            best_key = key;
         end
      end
      return best;
   endfunction

   // Store one request; on the closing request, queue the whole service order
   function automatic void take_request(input logic [FLD_W-1:0] trk, input logic lst);
      int               total;
      int               s;
      move_type         mv;
      logic [FLD_W-1:0] d;
      if (slot_count < MAX_SLOTS) begin
         trk_slot[slot_count]  = trk;
         slot_live[slot_count] = 1'b1;
         slot_count++;
      end else begin
         drop_seen = 1'b1;
      end
      if (!lst) return;

      head_track = cfg_start;
      seek_acc   = '0;
      going_up   = 1'b1;
      total      = slot_count;
      for (int k = 0; k < total; k++) begin
         case (cfg_policy)
            POL_LOOK: begin
               if (going_up) begin
                  s = best_slot(SEL_ABOVE);
                  if (s < 0) begin
                     going_up = 1'b0;
                     s = best_slot(SEL_BELOW);
                  end
               end else begin
                  s = best_slot(SEL_BELOW);
                  if (s < 0) begin
                     going_up = 1'b1;
                     s = best_slot(SEL_ABOVE);
                  end
               end
            end
            POL_CLOOK: begin
               s = best_slot(SEL_ABOVE);
               if (s < 0) s = best_slot(SEL_LOWEST);
            end
            default: s = best_slot(SEL_NEAREST);
         endcase
         if (s < 0) break;
         d                = abs_diff(trk_slot[s], head_track);
         seek_acc         = seek_acc + d;
         mv.from_pos      = head_track;
         mv.to_pos        = trk_slot[s];
         mv.seek          = d;
         mv.total_seek    = seek_acc[SUM_W-1:0];
         mv.end_of_batch  = (k + 1 == total);
         mv.overflow      = drop_seen;
         expected_moves.push_back(mv);
         head_track       = trk_slot[s];
         slot_live[s]     = 1'b0;
      end

      // Start the next batch fresh; its head is set from the start register when it closes
      for (int i = 0; i < MAX_SLOTS; i++) slot_live[i] = 1'b0;
      slot_count = 0;
      going_up   = 1'b1;
      drop_seen  = 1'b0;
   endfunction

   // Track config writes, predict on accepted requests, check accepted moves
   always @(posedge clock) begin
      move_type got;
      move_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_POLICY) cfg_policy = csr_data[1:0];
            else if (csr_index == CSR_START_HEAD) cfg_start = csr_data;
         end
         if (req_tvalid && req_tready) begin
            take_request(req_tdata, req_tlast);
            if (pin_next) begin
               void'(expected_moves.pop_back());
               expected_moves.push_back(pin_move);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.from_pos     = rsp_tdata[15:0];
            got.to_pos       = rsp_tdata[31:16];
            got.seek         = rsp_tdata[47:32];
            got.total_seek   = rsp_tdata[69:48];
            got.end_of_batch = rsp_tlast;
            got.overflow     = rsp_tuser;
            if (expected_moves.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected move: from=%h to=%h seek=%h total=%h last=%b ovf=%b",
                           got.from_pos, got.to_pos, got.seek, got.total_seek,
                           got.end_of_batch, got.overflow);
            end else begin
               want = expected_moves.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"move mismatch: exp from=%h to=%h seek=%h total=%h last=%b ",
                               "ovf=%b, got from=%h to=%h seek=%h total=%h last=%b ovf=%b"},
                              want.from_pos, want.to_pos, want.seek, want.total_seek,
                              want.end_of_batch, want.overflow,
                              got.from_pos, got.to_pos, got.seek, got.total_seek,
                              got.end_of_batch, got.overflow);
               end
            end
         end
         // Watchdog: count cycles without any transaction
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Receiver back-pressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rcv_idle);
   end

   // Drive one request transaction; entered and left on a falling edge
   task automatic send_req(input logic [FLD_W-1:0] trk, input logic lst);
      while ($urandom_range(0, 99) < snd_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= trk;
      req_tlast  <= lst;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx, input logic [FLD_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop valid, drain all expected moves, then let the scan pipeline go quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_moves.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic add_req(input logic [FLD_W-1:0] trk, input logic lst);
      dir_row_type r;
      r.kind = ROW_REQ; r.idx = '0; r.val = trk; r.lst = lst; r.pinned = 1'b0; r.mv = '0;
      dir_rows.push_back(r);
   endtask

   // Single-request batch whose move is known by inspection
   task automatic add_pin(input logic [FLD_W-1:0] trk, input logic [FLD_W-1:0] from_pos,
                          input logic [FLD_W-1:0] seek);
      dir_row_type r;
      r.kind = ROW_REQ; r.idx = '0; r.val = trk; r.lst = 1'b1; r.pinned = 1'b1;
      r.mv = '{from_pos, trk, seek, {{(SUM_W - FLD_W){1'b0}}, seek}, 1'b1, 1'b0};
      dir_rows.push_back(r);
   endtask

   task automatic add_cfg(input logic [CSR_IDX_BITS-1:0] idx, input logic [FLD_W-1:0] val);
      dir_row_type r;
      r.kind = ROW_CFG; r.idx = idx; r.val = val; r.lst = 1'b0; r.pinned = 1'b0; r.mv = '0;
      dir_rows.push_back(r);
   endtask

   // Random track: extremes, near the start head, repeats, or anything
   function automatic logic [FLD_W-1:0] pick_track();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return cfg_start + FLD_W'($urandom_range(0, 64)) - FLD_W'(32);
         3:       return prev_track;
         default: return FLD_W'($urandom);
      endcase
   endfunction

   initial begin
      row_kind_type     prev_kind;
      int               phase_items;
      int               batch_len;
      logic [FLD_W-1:0] trk;

      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
         trk_slot[i]  = '0;
         slot_live[i] = 1'b0;
      end

      // Directed rows: extremes, ties, every policy, equal-to-head tracks
      add_pin(16'h0000, 16'h0000, 16'h0000);
      add_pin(16'hFFFF, 16'h0000, 16'hFFFF);
      add_cfg(CSR_START_HEAD, 16'hFFFF);
      add_pin(16'h0000, 16'hFFFF, 16'hFFFF);
      add_cfg(CSR_START_HEAD, 16'd200);
      add_req(16'd100, 1'b0);
      add_req(16'd300, 1'b0);
      add_req(16'd200, 1'b1);
      add_req(16'd5000, 1'b0);
      add_req(16'd5000, 1'b0);
      add_req(16'd4990, 1'b1);
      add_cfg(CSR_POLICY, POL_LOOK);
      add_req(16'd300, 1'b0);
      add_req(16'd100, 1'b0);
      add_req(16'd250, 1'b0);
      add_req(16'd200, 1'b1);
      add_req(16'd100, 1'b0);
      add_req(16'd50, 1'b1);
      add_cfg(CSR_POLICY, POL_CLOOK);
      add_req(16'd300, 1'b0);
      add_req(16'd100, 1'b0);
      add_req(16'd150, 1'b0);
      add_req(16'd250, 1'b1);
      add_cfg(CSR_POLICY, 16'hFFFF);   // unused code 3 falls back to shortest seek
      add_cfg(CSR_SPARE, 16'hA5A5);
      add_req(16'd7, 1'b0);
      add_req(16'd400, 1'b1);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Walk the directed table
      prev_kind = ROW_CFG;
      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CFG) begin
            if (prev_kind == ROW_REQ) settle();
            write_reg(dir_rows[i].idx, dir_rows[i].val);
         end else begin
            if (prev_kind == ROW_CFG) csr_valid <= 1'b0;
            pin_next = dir_rows[i].pinned;
            pin_move = dir_rows[i].mv;
            send_req(dir_rows[i].val, dir_rows[i].lst);
         end
         prev_kind = dir_rows[i].kind;
      end
      pin_next = 1'b0;

      // Random phases: new settings each phase, batches of random content
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph < 3) begin
            snd_idle = 8;  rcv_idle = 49;
         end else if (ph < 6) begin
            snd_idle = 49; rcv_idle = 8;
         end else begin
            snd_idle = 0;  rcv_idle = 0;
         end
         settle();
         write_reg(CSR_POLICY, {14'($urandom),
                                (ph < 4) ? 2'(ph) : 2'($urandom_range(0, 3))});
         write_reg(CSR_START_HEAD, (ph == 0) ? 16'h0000 :
                                   (ph == 1) ? 16'hFFFF : FLD_W'($urandom));
         if (ph == 5) write_reg(CSR_SPARE, FLD_W'($urandom));
         csr_valid <= 1'b0;

         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            // Mostly short batches; some fill or overrun the store
            batch_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36)
                                                    : $urandom_range(1, 8);
            for (int k = 0; k < batch_len; k++) begin
               trk = pick_track();
               prev_track = trk;
               send_req(trk, k == batch_len - 1);
            end
            phase_items += batch_len;
         end
      end

      // Drain and report
      req_tvalid <= 1'b0;
      while (expected_moves.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0 && expected_moves.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
